// ----- hdl/ucrr_pkg.sv -----
// Package for the UART command/reply block: character codes, reset values,
// reciprocal constants for the decimal split and small lookup functions.
// No dependencies.
package ucrr_pkg;

    localparam int unsigned CMD_LEN_DEFAULT = 8;
    localparam logic [15:0] RETRY_RESET     = 16'd300;

    localparam logic [7:0] CH_BANG = 8'h21;   // '!'
    localparam logic [7:0] CH_HASH = 8'h23;   // '#'
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;   // '0'

    localparam int unsigned RST_LEN = 3;
    localparam int unsigned OK_LEN  = 2;

    // Header bytes before the digits: CR LF ! A D C =
    localparam logic [3:0] HDR_LEN  = 4'd7;
    // Fixed part of a message: header plus '#' CR LF.
    localparam logic [3:0] BASE_LEN = 4'd10;

    // Reciprocal multipliers, exact for every 12-bit sample.
    localparam logic [24:0] DIV10_MUL    = 25'd6554;   // >> 16
    localparam logic [24:0] DIV100_MUL   = 25'd5243;   // >> 19
    localparam logic [25:0] DIV1000_MUL  = 26'd8389;   // >> 23
    localparam int unsigned DIV10_SHIFT   = 16;
    localparam int unsigned DIV100_SHIFT  = 19;
    localparam int unsigned DIV1000_SHIFT = 23;

    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = CH_CR;
            3'd1:    c = CH_LF;
            3'd2:    c = CH_BANG;
            3'd3:    c = 8'h41;   // 'A'
            3'd4:    c = 8'h44;   // 'D'
            3'd5:    c = 8'h43;   // 'C'
            3'd6:    c = 8'h3D;   // '='
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] rst_char(input logic [1:0] pos);
        logic [7:0] c;
        unique case (pos)
            2'd0:    c = 8'h52;   // 'R'
            2'd1:    c = 8'h53;   // 'S'
            2'd2:    c = 8'h54;   // 'T'
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ok_char(input logic pos);
        return pos ? 8'h4B : 8'h4F;   // 'K' : 'O'
    endfunction

endpackage

// ----- hdl/uart_command_reply_retransmit_core.sv -----
// Top level of the UART command/reply block: command deframer, retry timer
// and the reply message sequencer.
// Depends on ucrr_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one beat is a received byte
//   (func = 0) or a timer tick (func = 1). Commands are framed as !text#.
//   Output channel (out_valid / out_stall): one beat per reply character;
//   tx_last marks the final byte, led_toggle the first byte of a reply
//   caused by RST (never on a retransmission).
//   cfg_wr_en / cfg_wr_data write retry_period; write it only while idle.
//   Each input beat is handled in the cycle it is accepted, so a new beat
//   can be taken every cycle while in_stall is low. A beat that triggers a
//   reply parks it in a one-entry pending slot, from which the output
//   sequencer loads it once free. A reply is 11 to 14 bytes and the output
//   sequencer sends one byte per cycle when out_stall is low.
//   in_stall is high while the pending slot is full: in the cycle after
//   a reply is triggered, and for as long as an earlier reply is still
//   draining in front of it.
//   A stalled output byte holds until taken.
//   Reset clears all command and timer state and the sequencer valid flags
//   and byte index, and sets retry_period to 300; reply data is not reset.
module uart_command_reply_retransmit_core #(
    parameter int unsigned CMD_LEN = ucrr_pkg::CMD_LEN_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  rx_byte,
    input  logic [11:0] adc_sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  tx_byte,
    output logic        tx_last,
    output logic        led_toggle
);

    localparam int unsigned CNT_W = $clog2(CMD_LEN + 1);

    // Command and timer state
    logic [15:0]      retry_period_reg;
    logic             in_body_reg, in_body_next;
    logic [CNT_W-1:0] cmd_count_reg, cmd_count_next;
    logic             cmd_overflow_reg, cmd_overflow_next;
    logic             rst_match_reg, rst_match_next;
    logic             ok_match_reg, ok_match_next;
    logic             awaiting_ok_reg, awaiting_ok_next;
    logic [15:0]      ticks_left_reg, ticks_left_next;
    logic [11:0]      held_sample_reg, held_sample_next;

    // Pending reply slot
    logic             pend_valid_reg, pend_valid_next;
    logic [11:0]      pend_sample_reg;
    logic             pend_led_reg;

    // Active reply being sent
    logic             act_valid_reg, act_valid_next;
    logic [3:0]       act_idx_reg, act_idx_next;
    logic [2:0]       act_nd_reg;
    logic             act_led_reg;
    logic [3:0]       act_dig_reg [4];

    logic             in_fire, out_fire, load;
    logic             send, send_led;
    logic [11:0]      send_sample;
    logic             rst_hit, ok_hit;

    logic [24:0]      prod10, prod100;
    logic [25:0]      prod1000;
    logic [8:0]       q10;
    logic [5:0]       q100;
    logic [2:0]       q1000;
    logic [3:0]       dig0, dig1, dig2, dig3;
    logic [2:0]       nd_new;
    logic [3:0]       dig_new [4];

    logic [3:0]       act_len, from_end, dig_pos;

    assign in_stall  = pend_valid_reg;
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = act_valid_reg;
    assign out_fire  = act_valid_reg && !out_stall;
    assign load      = pend_valid_reg && (!act_valid_reg || (out_fire && tx_last));

    assign rst_hit = !cmd_overflow_reg && rst_match_reg
                     && (cmd_count_reg == CNT_W'(ucrr_pkg::RST_LEN));
    assign ok_hit  = !cmd_overflow_reg && ok_match_reg
                     && (cmd_count_reg == CNT_W'(ucrr_pkg::OK_LEN));

    // Per-beat command and timer update.
    always_comb
    begin
        in_body_next      = in_body_reg;
        cmd_count_next    = cmd_count_reg;
        cmd_overflow_next = cmd_overflow_reg;
        rst_match_next    = rst_match_reg;
        ok_match_next     = ok_match_reg;
        awaiting_ok_next  = awaiting_ok_reg;
        ticks_left_next   = ticks_left_reg;
        held_sample_next  = held_sample_reg;
        send              = 1'b0;
        send_led          = 1'b0;
        send_sample       = held_sample_reg;

        if (in_fire)
        begin
            priority if (func)
            begin
                if (awaiting_ok_reg)
                begin
                    if (ticks_left_reg <= 16'd1)
                    begin
                        ticks_left_next = retry_period_reg;
                        send            = 1'b1;
                    end
                    else
                    begin
                        ticks_left_next = ticks_left_reg - 16'd1;
                    end
                end
            end
            else if (!in_body_reg)
            begin
                if (rx_byte == ucrr_pkg::CH_BANG)
                begin
                    in_body_next      = 1'b1;
                    cmd_count_next    = '0;
                    cmd_overflow_next = 1'b0;
                    rst_match_next    = 1'b1;
                    ok_match_next     = 1'b1;
                end
            end
            else if (rx_byte == ucrr_pkg::CH_BANG)
            begin
                // A stray start mark inside a body is skipped.
            end
            else if (rx_byte == ucrr_pkg::CH_HASH)
            begin
                in_body_next = 1'b0;
                if (!awaiting_ok_reg)
                begin
                    if (rst_hit)
                    begin
                        held_sample_next = adc_sample;
                        awaiting_ok_next = 1'b1;
                        ticks_left_next  = retry_period_reg;
                        send             = 1'b1;
                        send_led         = 1'b1;
                        send_sample      = adc_sample;
                    end
                end
                else if (ok_hit)
                begin
                    awaiting_ok_next = 1'b0;
                end
            end
            else if (cmd_count_reg < CNT_W'(CMD_LEN))
            begin
                // Match flags track each keyword position by position, so the
                // body characters themselves need not be kept.
                cmd_count_next = cmd_count_reg + CNT_W'(1);
                rst_match_next = rst_match_reg
                                 && (cmd_count_reg < CNT_W'(ucrr_pkg::RST_LEN))
                                 && (rx_byte == ucrr_pkg::rst_char(cmd_count_reg[1:0]));
                ok_match_next  = ok_match_reg
                                 && (cmd_count_reg < CNT_W'(ucrr_pkg::OK_LEN))
                                 && (rx_byte == ucrr_pkg::ok_char(cmd_count_reg[0]));
            end
            else
            begin
                cmd_overflow_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_period_reg <= ucrr_pkg::RETRY_RESET;
            in_body_reg      <= 1'b0;
            cmd_count_reg    <= '0;
            cmd_overflow_reg <= 1'b0;
            rst_match_reg    <= 1'b0;
            ok_match_reg     <= 1'b0;
            awaiting_ok_reg  <= 1'b0;
            ticks_left_reg   <= '0;
            held_sample_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                retry_period_reg <= cfg_wr_data;
            end
            in_body_reg      <= in_body_next;
            cmd_count_reg    <= cmd_count_next;
            cmd_overflow_reg <= cmd_overflow_next;
            rst_match_reg    <= rst_match_next;
            ok_match_reg     <= ok_match_next;
            awaiting_ok_reg  <= awaiting_ok_next;
            ticks_left_reg   <= ticks_left_next;
            held_sample_reg  <= held_sample_next;
        end
    end

    // Decimal split of the pending sample by reciprocal multiplication.
    always_comb
    begin
        prod10   = 25'(pend_sample_reg) * ucrr_pkg::DIV10_MUL;
        prod100  = 25'(pend_sample_reg) * ucrr_pkg::DIV100_MUL;
        prod1000 = 26'(pend_sample_reg) * ucrr_pkg::DIV1000_MUL;
        q10      = prod10[ucrr_pkg::DIV10_SHIFT +: 9];
        q100     = prod100[ucrr_pkg::DIV100_SHIFT +: 6];
        q1000    = prod1000[ucrr_pkg::DIV1000_SHIFT +: 3];
        dig0     = 4'(pend_sample_reg - 12'({q10, 3'b000}) - 12'({q10, 1'b0}));
        dig1     = 4'(q10 - 9'({q100, 3'b000}) - 9'({q100, 1'b0}));
        dig2     = 4'(q100 - 6'({q1000, 3'b000}) - 6'({q1000, 1'b0}));
        dig3     = {1'b0, q1000};

        // Digits are left-aligned, most significant first, no leading zeros.
        dig_new[0] = dig0;
        dig_new[1] = '0;
        dig_new[2] = '0;
        dig_new[3] = '0;
        priority if (dig3 != 4'd0)
        begin
            nd_new     = 3'd4;
            dig_new[0] = dig3;
            dig_new[1] = dig2;
            dig_new[2] = dig1;
            dig_new[3] = dig0;
        end
        else if (dig2 != 4'd0)
        begin
            nd_new     = 3'd3;
            dig_new[0] = dig2;
            dig_new[1] = dig1;
            dig_new[2] = dig0;
        end
        else if (dig1 != 4'd0)
        begin
            nd_new     = 3'd2;
            dig_new[0] = dig1;
            dig_new[1] = dig0;
        end
        else
        begin
            nd_new = 3'd1;
        end
    end

    // Pending slot and output sequencer control.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        act_valid_next  = act_valid_reg;
        act_idx_next    = act_idx_reg;
        if (send)
        begin
            pend_valid_next = 1'b1;
        end
        else if (load)
        begin
            pend_valid_next = 1'b0;
        end

        if (load)
        begin
            act_valid_next = 1'b1;
            act_idx_next   = '0;
        end
        else if (out_fire)
        begin
            if (tx_last)
            begin
                act_valid_next = 1'b0;
            end
            else
            begin
                act_idx_next = act_idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            act_valid_reg  <= 1'b0;
            act_idx_reg    <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            act_valid_reg  <= act_valid_next;
            act_idx_reg    <= act_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (send)
        begin
            pend_sample_reg <= send_sample;
            pend_led_reg    <= send_led;
        end
        if (load)
        begin
            act_nd_reg  <= nd_new;
            act_led_reg <= pend_led_reg;
            for (int i = 0; i < 4; i++)
            begin
                act_dig_reg[i] <= dig_new[i];
            end
        end
    end

    // Output byte selection: tail counted from the end, header from the start.
    always_comb
    begin
        act_len  = ucrr_pkg::BASE_LEN + {1'b0, act_nd_reg};
        from_end = act_len - 4'd1 - act_idx_reg;
        dig_pos  = act_idx_reg - ucrr_pkg::HDR_LEN;
        priority if (from_end == 4'd0)
        begin
            tx_byte = ucrr_pkg::CH_LF;
        end
        else if (from_end == 4'd1)
        begin
            tx_byte = ucrr_pkg::CH_CR;
        end
        else if (from_end == 4'd2)
        begin
            tx_byte = ucrr_pkg::CH_HASH;
        end
        else if (act_idx_reg < ucrr_pkg::HDR_LEN)
        begin
            tx_byte = ucrr_pkg::hdr_char(act_idx_reg[2:0]);
        end
        else
        begin
            tx_byte = ucrr_pkg::CH_ZERO + {4'b0000, act_dig_reg[dig_pos[1:0]]};
        end
        tx_last    = (from_end == 4'd0);
        led_toggle = act_led_reg && (act_idx_reg == 4'd0);
    end

`ifndef NO_ASSERTIONS
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && !act_valid_reg |=> act_valid_reg && !pend_valid_reg)
        else $error("pending reply not moved into a free sequencer");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> act_idx_reg < act_len)
        else $error("reply byte index beyond message length");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_last |-> (act_idx_reg >= 4'd10) && (act_idx_reg <= 4'd13))
        else $error("reply length outside 11 to 14 bytes");

    a_led_first_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && led_toggle |-> !tx_last && (tx_byte == ucrr_pkg::CH_CR))
        else $error("led toggle not on the opening byte");

    a_msg_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !tx_last |=> out_valid)
        else $error("reply ended before its last byte");
`endif

endmodule
